>>> src/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared types and codes for the Morse symbol decoder
// Table entry layout, result layout, opcodes, kinds, status codes and the
// character codes that the decoder recognizes.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Default longest code; the table holds 2^(MAX_CODE_LENGTH+1) entries
  localparam int MSD_MAX_CODE_LENGTH = 6;

  // Opcodes (travel on in_tuser)
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Table entry kinds
  localparam logic [1:0] KIND_ABSENT = 2'd0;
  localparam logic [1:0] KIND_INNER  = 2'd1;
  localparam logic [1:0] KIND_LETTER = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result status codes (travel on out_tuser)
  localparam logic [2:0] ST_LETTER    = 3'd0;
  localparam logic [2:0] ST_SPACE     = 3'd1;
  localparam logic [2:0] ST_NO_LETTER = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NULL  = 8'h00;

  // One code table entry
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] letter;
  } entry_t;

  // One input item, held in the input register
  typedef struct packed {
    logic       opcode;
    logic [7:0] char_byte;
    logic       eom;
    logic [6:0] entry_index;
    logic [1:0] entry_kind;
    logic [7:0] entry_letter;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_char;
    logic [2:0] status;
    logic       last;
  } result_t;

  // Up to two results produced by one item
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // Table write request (address travels beside it)
  typedef struct packed {
    logic   en;
    entry_t data;
  } tbl_wr_t;

  // Result for emitting a node
  function automatic result_t emit_entry(entry_t e);
    result_t r;
    r = '0;
    case (e.kind)
      KIND_LETTER: begin
        r.out_char = e.letter;
        r.status   = ST_LETTER;
      end
      KIND_INNER:  r.status = ST_NO_LETTER;
      default:     r.status = ST_NOT_FOUND;
    endcase
    return r;
  endfunction

  // Result with a fixed status and character
  function automatic result_t make_result(logic [7:0] ch, logic [2:0] st);
    result_t r;
    r.out_char = ch;
    r.status   = st;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

>>> src/msd_table.sv
// ----------------------------------------------------------------------------
// msd_table: code tree table
// One write port and two registered read ports that fetch both children of
// the next node position. Valid bits give the cleared state after reset.
// ----------------------------------------------------------------------------
module msd_table #(
  parameter int AW = msd_pkg::MSD_MAX_CODE_LENGTH + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  msd_pkg::tbl_wr_t wr,
  input  logic [AW-1:0]   wr_addr,
  input  logic [AW-1:0]   pos_nxt,
  output msd_pkg::entry_t dot_entry,
  output msd_pkg::entry_t dash_entry
);
  import msd_pkg::*;

  localparam int DEPTH = 1 << AW;

  entry_t          mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  entry_t          dot_r;
  entry_t          dash_r;

  logic            kids_in_range;
  logic [AW-1:0]   dot_addr;
  logic [AW-1:0]   dash_addr;

  // children of the next position; none when the node sits at max depth
  assign kids_in_range = ~pos_nxt[AW-1];
  assign dot_addr      = {pos_nxt[AW-2:0], 1'b0};
  assign dash_addr     = {pos_nxt[AW-2:0], 1'b1};

  // storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered child reads with write-through forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= '0;
      dash_r <= '0;
    end else begin
      if (!kids_in_range) begin
        dot_r <= '0;
      end else if (wr.en && wr_addr == dot_addr) begin
        dot_r <= wr.data;
      end else if (valid_r[dot_addr]) begin
        dot_r <= mem[dot_addr];
      end else begin
        dot_r <= '0;
      end

      if (!kids_in_range) begin
        dash_r <= '0;
      end else if (wr.en && wr_addr == dash_addr) begin
        dash_r <= wr.data;
      end else if (valid_r[dash_addr]) begin
        dash_r <= mem[dash_addr];
      end else begin
        dash_r <= '0;
      end
    end
  end

  assign dot_entry  = dot_r;
  assign dash_entry = dash_r;

endmodule

>>> src/msd_step.sv
// ----------------------------------------------------------------------------
// msd_step: decode step
// Combinational next-state and result logic for one item taken from the
// input register: tree walk, letter emit, error drop and table loads.
// ----------------------------------------------------------------------------
module msd_step #(
  parameter int AW = msd_pkg::MSD_MAX_CODE_LENGTH + 1
) (
  input  logic                  fire,
  input  msd_pkg::item_t        item,
  input  logic [AW-1:0]         pos,
  input  logic                  err,
  input  msd_pkg::entry_t       cur,
  input  msd_pkg::entry_t       dot_entry,
  input  msd_pkg::entry_t       dash_entry,
  output logic [AW-1:0]         pos_nxt,
  output logic                  err_nxt,
  output msd_pkg::entry_t       cur_nxt,
  output msd_pkg::result_pair_t res,
  output msd_pkg::tbl_wr_t      wr,
  output logic [AW-1:0]         wr_addr
);
  import msd_pkg::*;

  localparam int            CW   = (AW > 7) ? AW : 7;
  localparam logic [AW-1:0] ROOT = AW'(1);

  logic [CW-1:0] idx_ext;
  logic          idx_in_range;
  logic [AW-1:0] pos_a;
  entry_t        cur_a;
  entry_t        child;
  logic          is_dash;
  logic          failed;
  result_t       r0;
  result_t       r1;
  logic [1:0]    cnt;

  // load index: nonzero and inside the table
  assign idx_ext      = CW'(item.entry_index);
  assign idx_in_range = (idx_ext >> AW) == '0;
  assign wr_addr      = idx_ext[AW-1:0];

  assign is_dash = (item.char_byte == CH_DASH);
  assign child   = is_dash ? dash_entry : dot_entry;

  always_comb begin
    pos_nxt = pos;
    err_nxt = err;
    cur_nxt = cur;
    wr      = '0;
    res     = '0;
    pos_a   = pos;
    cur_a   = cur;
    failed  = 1'b0;
    r0      = '0;
    r1      = '0;
    cnt     = 2'd0;

    if (fire) begin
      if (item.opcode == OP_LOAD) begin
        // table load; kind 3 is stored as absent
        wr.en          = (idx_ext != '0) && idx_in_range;
        wr.data.kind   = (item.entry_kind == KIND_UNUSED) ? KIND_ABSENT : item.entry_kind;
        wr.data.letter = item.entry_letter;
        if (wr.en && wr_addr == pos) begin
          cur_nxt = wr.data;
        end
      end else if (err) begin
        // dropping the rest of a message
        if (item.eom) begin
          err_nxt = 1'b0;
          pos_nxt = ROOT;
          cur_nxt = '0;
        end
      end else begin
        unique case (item.char_byte) inside
          [CH_TAB:CH_CR], CH_SPACE: begin
            if (pos != ROOT) begin
              r0    = emit_entry(cur);
              cnt   = 2'd1;
              pos_a = ROOT;
              cur_a = '0;
            end
          end
          CH_SLASH: begin
            r0  = make_result(CH_SPACE, ST_SPACE);
            cnt = 2'd1;
          end
          CH_DOT, CH_DASH: begin
            if (child.kind == KIND_ABSENT) begin
              r0     = make_result(CH_NULL, ST_NOT_FOUND);
              cnt    = 2'd1;
              failed = 1'b1;
            end else begin
              pos_a = {pos[AW-2:0], is_dash};
              cur_a = child;
            end
          end
          default: begin
            r0     = make_result(CH_NULL, ST_INVALID);
            cnt    = 2'd1;
            failed = 1'b1;
          end
        endcase

        // error return, or flush of a pending node at end of message
        if (failed) begin
          pos_a = ROOT;
          cur_a = '0;
          if (!item.eom) begin
            err_nxt = 1'b1;
          end
        end else if (item.eom && pos_a != ROOT) begin
          if (cnt == 2'd0) begin
            r0 = emit_entry(cur_a);
          end else begin
            r1 = emit_entry(cur_a);
          end
          cnt   = cnt + 2'd1;
          pos_a = ROOT;
          cur_a = '0;
        end

        // mark the final result of the message
        if (item.eom) begin
          if (cnt == 2'd2) begin
            r1.last = 1'b1;
          end else if (cnt == 2'd1) begin
            r0.last = 1'b1;
          end
        end

        pos_nxt    = pos_a;
        cur_nxt    = cur_a;
        res.count  = cnt;
        res.first  = r0;
        res.second = r1;
      end
    end
  end

endmodule

>>> src/msd_out_buf.sv
// ----------------------------------------------------------------------------
// msd_out_buf: result register
// Holds the up to two results of one item and hands them out one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
module msd_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  msd_pkg::result_pair_t pair,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output msd_pkg::result_t      head
);
  import msd_pkg::*;

  result_t    head_r;
  result_t    head_nxt;
  result_t    tail_r;
  result_t    tail_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign head      = head_r;

  // load a new pair or shift after a transaction
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      head_nxt = pair.first;
      tail_nxt = pair.second;
      cnt_nxt  = pair.count;
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

>>> src/morse_symbol_decoder.sv
// ----------------------------------------------------------------------------
// morse_symbol_decoder: Morse code tree decoder
// Walks a heap-indexed code tree on dot and underscore characters and emits
// letters, word spaces and error codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): opcode on in_tuser (0 decode, 1 table load),
//   end of message on in_tlast, the other fields packed in in_tdata.
//   Load the code tree first with load transactions, then send characters.
//   Result channel (out_*): character in out_tdata, status in out_tuser,
//   out_tlast on the final result of an end-of-message item.
//   Path: an accepted item waits in the input register until the result
//   register has room, then its results are registered there.
//   Throughput: one item per cycle while the result register has room; the
//   single pass through the input register, the step logic and the result
//   register sets this. An item with two results holds the result register
//   for two transactions, so the input stalls while both are held.
//   Each item reads both children of the current node from the table, which
//   are fetched ahead from the next position through two registered read ports.
//   Reset: the table reads as all absent at once (valid bits), the position
//   returns to the root and pending results are discarded; no clearing pass.
//   Receiver stall: results stay in the result register and in_tready drops
//   once the input register holds an item that cannot be processed.
// ----------------------------------------------------------------------------
module morse_symbol_decoder #(
  parameter int MAX_CODE_LENGTH = msd_pkg::MSD_MAX_CODE_LENGTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_byte[7:0], entry_index[14:8],
                                  // entry_kind[16:15], entry_letter[24:17]
  input  logic        in_tuser,   // opcode[0]
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_char[7:0]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast   // last
);
  import msd_pkg::*;

  localparam int            AW   = MAX_CODE_LENGTH + 1;
  localparam logic [AW-1:0] ROOT = AW'(1);

  item_t         item_r;
  logic          in_vld_r;
  logic [AW-1:0] pos_r;
  logic [AW-1:0] pos_nxt;
  logic          err_r;
  logic          err_nxt;
  entry_t        cur_r;
  entry_t        cur_nxt;
  entry_t        dot_entry;
  entry_t        dash_entry;
  tbl_wr_t       wr;
  logic [AW-1:0] wr_addr;
  result_pair_t  res;
  result_t       head;
  logic          room;
  logic          fire;

  // process the held item when the result register can take its results
  assign fire      = in_vld_r && room;
  assign in_tready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.opcode       <= in_tuser;
      item_r.char_byte    <= in_tdata[7:0];
      item_r.eom          <= in_tlast;
      item_r.entry_index  <= in_tdata[14:8];
      item_r.entry_kind   <= in_tdata[16:15];
      item_r.entry_letter <= in_tdata[24:17];
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= ROOT;
      err_r <= 1'b0;
      cur_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      err_r <= err_nxt;
      cur_r <= cur_nxt;
    end
  end

  msd_table #(.AW(AW)) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .pos_nxt    (pos_nxt),
    .dot_entry  (dot_entry),
    .dash_entry (dash_entry)
  );

  msd_step #(.AW(AW)) u_step (
    .fire       (fire),
    .item       (item_r),
    .pos        (pos_r),
    .err        (err_r),
    .cur        (cur_r),
    .dot_entry  (dot_entry),
    .dash_entry (dash_entry),
    .pos_nxt    (pos_nxt),
    .err_nxt    (err_nxt),
    .cur_nxt    (cur_nxt),
    .res        (res),
    .wr         (wr),
    .wr_addr    (wr_addr)
  );

  msd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .pair      (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = head.out_char;
  assign out_tuser = head.status;
  assign out_tlast = head.last;

endmodule

>>> src/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker: port checks for the Morse symbol decoder
// Watches the result channel: stall behavior, reset, and consistency between
// the status code and the character it carries.
// ----------------------------------------------------------------------------
module msd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import msd_pkg::*;

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset discards pending results
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // status stays within its codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_INVALID)
    else $error("status code out of range");

  // a word space carries the space character
  a_space_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SPACE |-> out_tdata == CH_SPACE)
    else $error("word space without space character");

  // error results carry a zero character
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NO_LETTER || out_tuser == ST_NOT_FOUND ||
    out_tuser == ST_INVALID) |-> out_tdata == CH_NULL)
    else $error("error result with nonzero character");

endmodule

bind morse_symbol_decoder msd_checker u_msd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Morse symbol decoder
// Loads code trees of varied shape through load transactions, then streams
// dot/underscore messages with separators, word spaces and junk bytes. A
// scoreboard class walks its own copy of the tree for every accepted input
// transaction and checks each result transaction in order. Both stream sides
// idle at random; long receiver hold-offs in two phases back the block up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  localparam logic [6:0] ROOT_NODE  = 7'd1;
  localparam int         ITEM_QUOTA = 1950;
  localparam int         HOLD_OFF   = 400;

  // --------------------------------------------------------------------------
  // Scoreboard: tree walker and queue of expected decoded symbols
  // --------------------------------------------------------------------------
  class symbol_scoreboard;
    logic [1:0] kind_tab [128];
    logic [7:0] letter_tab [128];
    logic [6:0] node;
    bit         dropping;
    result_t    pending_symbols [$];
    int         errors;

    function new();
      for (int i = 0; i < 128; i++) begin
        kind_tab[i]   = KIND_ABSENT;
        letter_tab[i] = 8'd0;
      end
      node     = ROOT_NODE;
      dropping = 1'b0;
      errors   = 0;
    endfunction

    function result_t symbol(logic [7:0] ch, logic [2:0] st);
      result_t r;
      r.out_char = ch;
      r.status   = st;
      r.last     = 1'b0;
      return r;
    endfunction

    // Children past the last table entry count as absent
    function logic [1:0] kind_at(logic [7:0] idx);
      return idx[7] ? KIND_ABSENT : kind_tab[idx[6:0]];
    endfunction

    // Symbol for the current node; walk returns to the root
    function result_t take_node_symbol();
      result_t r;
      case (kind_tab[node])
        KIND_LETTER: r = symbol(letter_tab[node], ST_LETTER);
        KIND_INNER:  r = symbol(8'd0, ST_NO_LETTER);
        default:     r = symbol(8'd0, ST_NOT_FOUND);
      endcase
      node = ROOT_NODE;
      return r;
    endfunction

    // Predict the symbols caused by one accepted input transaction
    function void decode_item(logic op, logic [7:0] ch, logic eom, logic [6:0] idx,
                              logic [1:0] kind, logic [7:0] letter);
      result_t    got [2];
      int         n;
      logic [7:0] child;
      logic       is_blank;
      logic       failed;
      n      = 0;
      failed = 1'b0;
      // Table load: no result, decode state untouched
      if (op == OP_LOAD) begin
        if (idx != 7'd0) begin
          kind_tab[idx]   = (kind == KIND_UNUSED) ? KIND_ABSENT : kind;
          letter_tab[idx] = letter;
        end
        return;
      end
      // Rest of a failed message is dropped
      if (dropping) begin
        if (eom) begin
          dropping = 1'b0;
          node     = ROOT_NODE;
        end
        return;
      end
      is_blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
      if (is_blank) begin
        if (node != ROOT_NODE) begin
          got[n] = take_node_symbol();
          n++;
        end
      end else if (ch == CH_SLASH) begin
        got[n] = symbol(CH_SPACE, ST_SPACE);
        n++;
      end else if (ch == CH_DOT || ch == CH_DASH) begin
        child = {node, ch == CH_DASH};
        if (kind_at(child) == KIND_ABSENT) begin
          got[n] = symbol(8'd0, ST_NOT_FOUND);
          n++;
          failed = 1'b1;
        end else begin
          node = child[6:0];
        end
      end else begin
        got[n] = symbol(8'd0, ST_INVALID);
        n++;
        failed = 1'b1;
      end
      // Error handling, then end-of-message flush
      if (failed) begin
        node = ROOT_NODE;
        if (!eom) dropping = 1'b1;
      end else if (eom && node != ROOT_NODE) begin
        got[n] = take_node_symbol();
        n++;
      end
      if (eom && n > 0) got[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) pending_symbols.push_back(got[k]);
    endfunction

    // Compare one result transaction with the oldest expected symbol
    function void check_symbol(logic [7:0] ch, logic [2:0] st, logic last);
      result_t want;
      if (pending_symbols.size() == 0) begin
        $display("%0t: unexpected result: char %0d status %0d last %0d",
                 $time, ch, st, last);
        errors++;
        return;
      end
      want = pending_symbols.pop_front();
      if (ch !== want.out_char) begin
        $display("%0t: out_char expected %0d actual %0d", $time, want.out_char, ch);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and DUT
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = 32'd0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  symbol_scoreboard sb;
  int  item_count    = 0;
  int  burst_left    = 0;
  bit  steady        = 1'b0;
  bit  hold_off_req  = 1'b0;
  int  hold_left     = 0;
  int  cyc           = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  morse_symbol_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Result side: check transactions, then pick next ready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_symbol(out_tdata, out_tuser, out_tlast);
    cyc++;
    if (hold_off_req) begin
      hold_left    = HOLD_OFF;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case ((cyc / 300) % 4)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ((cyc % 4) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input side drivers
  // --------------------------------------------------------------------------
  // One input transaction, in bursts with random gaps between them
  task automatic send_item(input logic op, input logic [7:0] ch, input logic eom,
                           input logic [6:0] idx, input logic [1:0] kind,
                           input logic [7:0] letter);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= eom;
    in_tdata  <= {7'd0, letter, kind, idx, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.decode_item(op, ch, eom, idx, kind, letter);
    item_count++;
  endtask

  // Decode character; load fields carry junk
  task automatic send_char(input logic [7:0] ch, input logic eom);
    send_item(OP_DECODE, ch, eom, 7'($urandom_range(0, 127)),
              2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Table entry load; character fields carry junk
  task automatic load_entry(input logic [6:0] idx, input logic [1:0] kind,
                            input logic [7:0] letter);
    send_item(OP_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              idx, kind, letter);
  endtask

  // Hold input idle until every expected symbol has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_symbols.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(9 + r);
  endfunction

  // Whole tree: each entry letter, inner or absent by the given odds
  task automatic load_table(input int letter_pct, input int inner_pct);
    int         r;
    logic [1:0] kind;
    load_entry(7'd0, KIND_LETTER, 8'($urandom_range(0, 255)));
    for (int i = 1; i < 128; i++) begin
      r = $urandom_range(0, 99);
      if (r < letter_pct)                  kind = KIND_LETTER;
      else if (r < letter_pct + inner_pct) kind = KIND_INNER;
      else                                 kind = r[0] ? KIND_UNUSED : KIND_ABSENT;
      load_entry(7'(i), kind, 8'($urandom_range(0, 255)));
    end
  endtask

  // Well-formed message with random codes; some codes run past the table
  task automatic send_message(input int letters);
    int   len;
    int   r;
    bit   final_one;
    bit   flush_on_code;
    for (int l = 0; l < letters; l++) begin
      final_one     = (l == letters - 1);
      flush_on_code = final_one && ($urandom_range(0, 2) == 0);
      len = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        // occasional table rewrite in the middle of a code
        if ($urandom_range(0, 29) == 0)
          load_entry(7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)));
        send_char($urandom_range(0, 1) ? CH_DASH : CH_DOT,
                  flush_on_code && (k == len - 1));
      end
      if (!flush_on_code) begin
        r = $urandom_range(0, 39);
        if (r == 0)      send_char(8'($urandom_range(0, 255)), final_one);
        else if (r < 7)  send_char(CH_SLASH, final_one);
        else if (r < 10) begin
          // blank pair: second one lands on the root
          send_char(pick_blank(), 1'b0);
          send_char(pick_blank(), final_one);
        end else         send_char(pick_blank(), final_one);
      end
    end
  endtask

  // Junk stream: any byte, random message ends, closed by an end of message
  task automatic send_noise(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 3);
      case (r)
        0:       send_char(CH_DOT, 1'b0);
        1:       send_char(CH_DASH, 1'b0);
        default: send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      endcase
    end
    send_char(pick_blank(), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    int phase_end;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tree after reset, index 0 load is ignored
    load_entry(7'd0, KIND_LETTER, 8'h5A);
    send_char(CH_DOT, 1'b1);
    // Small tree: E=. T=_ inner=.. A=._ , unused kind at __ , deepest slot
    load_entry(7'd2, KIND_LETTER, 8'h45);
    load_entry(7'd3, KIND_LETTER, 8'h54);
    load_entry(7'd4, KIND_INNER, 8'h00);
    load_entry(7'd5, KIND_LETTER, 8'h41);
    load_entry(7'd7, KIND_UNUSED, 8'h51);
    load_entry(7'd127, KIND_LETTER, 8'hFF);
    send_char(CH_DOT, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_DASH, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(8'd10, 1'b0);            // blank at root: skipped
    send_char(CH_SLASH, 1'b0);
    // missing child, then the rest of the message is dropped
    send_char(CH_DASH, 1'b0);
    send_char(CH_DASH, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_SLASH, 1'b1);
    // invalid bytes at both ends of the range
    send_char(CH_NULL, 1'b0);
    send_char(CH_SPACE, 1'b1);
    send_char(8'hFF, 1'b1);
    // inner node flushed by the end of message
    send_char(CH_DOT, 1'b0);
    send_char(CH_DOT, 1'b1);
    // node removed under the walk: absent without dropping
    send_char(CH_DOT, 1'b0);
    load_entry(7'd2, KIND_ABSENT, 8'h00);
    send_char(CH_CR, 1'b0);
    // word space plus pending letter on one item
    send_char(CH_DASH, 1'b0);
    send_char(CH_SLASH, 1'b1);
    drain();

    // Random phases, each on a freshly loaded tree
    phase = 0;
    while (item_count < ITEM_QUOTA) begin
      drain();
      case (phase % 4)
        0:       load_table(85, 10);
        1:       load_table(50, 15);
        2:       load_table(20, 70);
        default: load_table(95, 5);
      endcase
      if (phase == 1 || phase == 3) hold_off_req = 1'b1;
      phase_end = item_count + 300;
      while (item_count < phase_end && item_count < ITEM_QUOTA) begin
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 6) == 0) send_noise($urandom_range(1, 12));
        else                           send_message($urandom_range(1, 8));
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_symbols.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
